/* src/sma_pkg.sv */
// Shared types and constants for the stack machine ALU.
// No dependencies; the interfaces and the top level refer to it by scoped names.

package sma_pkg;

    localparam int unsigned WORD_W          = 64;
    localparam int unsigned OP_W            = 3;
    localparam int unsigned DEPTH_W         = 11;
    localparam int unsigned STATUS_W        = 2;
    localparam int unsigned STEP_W          = $clog2(WORD_W);
    localparam int unsigned STACK_DEPTH_DEF = 1024;

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_DONE
    } state_t;

endpackage

/* src/sma_req_if.sv */
// Request channel: one instruction word per handshake.
// Depends on sma_pkg.

interface sma_req_if;
    logic                         valid;
    logic                         ready;
    logic [sma_pkg::OP_W-1:0]     req_type;
    sma_pkg::word_t               operand;

    modport source (output valid, output req_type, output operand, input ready);
    modport sink   (input valid, input req_type, input operand, output ready);
endinterface

/* src/sma_rsp_if.sv */
// Response channel: top of stack, depth and status per instruction.
// Depends on sma_pkg.

interface sma_rsp_if;
    logic                         valid;
    logic                         ready;
    sma_pkg::word_t               top_value;
    logic [sma_pkg::DEPTH_W-1:0]  stack_depth;
    logic [sma_pkg::STATUS_W-1:0] status;

    modport source (output valid, output top_value, output stack_depth, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_depth, input status,
                    output ready);
endinterface

/* src/stack_machine_alu.sv */
// 64-bit stack machine ALU: top level with sequencer and shared adder datapath.
// Depends on sma_pkg, sma_req_if, sma_rsp_if and sma_ram.

// One instruction word is taken at a time; req.ready is low while it executes.
// Push, peek, unused codes and any underflow/overflow go from S_IDLE straight
// to S_DONE; add, sub and divide-by-zero pass through S_LOAD first. Mul and div
// add S_EXEC, in which the shared 65-bit adder runs a shift-add (mul) or
// restoring (div) step once per operand bit. The top of stack lives in a
// register; the entry below it is fetched from the stack RAM (one write and one
// registered read port). The RAM is not cleared after reset; only entries below
// the pointer are ever used. The result word sits in an output register, so a
// stalled sink only holds the block when the next result is ready.

module stack_machine_alu #(
    parameter int unsigned STACK_DEPTH = sma_pkg::STACK_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sma_req_if.sink   req,
    sma_rsp_if.source rsp
);

    localparam int unsigned PTR_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned SUM_W  = sma_pkg::WORD_W + 2;
    localparam logic [PTR_W-1:0] PTR_FULL = PTR_W'(STACK_DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W-1:0] PTR_TWO  = PTR_W'(2);

    sma_pkg::state_t                state_reg, state_next;
    logic [sma_pkg::OP_W-1:0]       op_reg, op_next;
    logic [sma_pkg::STATUS_W-1:0]   status_reg, status_next;
    sma_pkg::word_t                 res_reg, res_next;
    sma_pkg::word_t                 a_reg, a_next;
    sma_pkg::word_t                 b_reg, b_next;
    sma_pkg::word_t                 acc_reg, acc_next;
    logic [sma_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [PTR_W-1:0]               sp_reg, sp_next;
    sma_pkg::word_t                 top_reg, top_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    sma_pkg::word_t                 rsp_top_reg, rsp_top_next;
    logic [sma_pkg::DEPTH_W-1:0]    rsp_depth_reg, rsp_depth_next;
    logic [sma_pkg::STATUS_W-1:0]   rsp_status_reg, rsp_status_next;

    // fsm outputs
    logic accept;
    logic rsp_load;
    logic rd_en;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    sma_pkg::word_t       rd_data;
    logic                 is_binop;
    logic                 commit;
    logic                 last_step;

    // shared adder
    logic [SUM_W-2:0]     add_x, add_y;
    logic                 add_sub;
    logic [SUM_W-1:0]     add_sum;

    assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(SUM_W-1){add_sub}}}
                   + SUM_W'(add_sub);

    assign is_binop  = op_reg inside {sma_pkg::OP_ADD, sma_pkg::OP_SUB,
                                      sma_pkg::OP_MUL, sma_pkg::OP_DIV};
    assign commit    = (status_reg == sma_pkg::ST_OK) &&
                       (is_binop || (op_reg == sma_pkg::OP_PUSH));
    assign last_step = &step_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sma_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if ((req.req_type inside {sma_pkg::OP_ADD, sma_pkg::OP_SUB,
                                              sma_pkg::OP_MUL, sma_pkg::OP_DIV}) &&
                        (sp_reg >= PTR_TWO))
                    begin
                        state_next = sma_pkg::S_LOAD;
                    end
                    else
                    begin
                        state_next = sma_pkg::S_DONE;
                    end
                end
            end
            sma_pkg::S_LOAD:
            begin
                if ((op_reg == sma_pkg::OP_MUL) ||
                    ((op_reg == sma_pkg::OP_DIV) && (rd_data != '0)))
                begin
                    state_next = sma_pkg::S_EXEC;
                end
                else
                begin
                    state_next = sma_pkg::S_DONE;
                end
            end
            sma_pkg::S_EXEC:
            begin
                if (last_step)
                begin
                    state_next = sma_pkg::S_DONE;
                end
            end
            sma_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = sma_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sma_pkg::S_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        accept   = 1'b0;
        rsp_load = 1'b0;
        rd_en    = 1'b0;
        case (state_reg)
            sma_pkg::S_IDLE:
            begin
                accept = req.valid;
                rd_en  = req.valid;
            end
            sma_pkg::S_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        op_next         = op_reg;
        status_next     = status_reg;
        res_next        = res_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_top_next    = rsp_top_reg;
        rsp_depth_next  = rsp_depth_reg;
        rsp_status_next = rsp_status_reg;
        add_x           = {1'b0, top_reg};
        add_y           = {1'b0, rd_data};
        add_sub         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = ADDR_W'(sp_reg);

        case (state_reg)
            sma_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.req_type;
                    res_next    = req.operand;
                    status_next = sma_pkg::ST_OK;
                    case (req.req_type)
                        sma_pkg::OP_PUSH:
                        begin
                            if (sp_reg == PTR_FULL)
                            begin
                                status_next = sma_pkg::ST_OVER;
                            end
                        end
                        sma_pkg::OP_ADD, sma_pkg::OP_SUB, sma_pkg::OP_MUL, sma_pkg::OP_DIV:
                        begin
                            if (sp_reg < PTR_TWO)
                            begin
                                status_next = sma_pkg::ST_UNDER;
                            end
                        end
                        sma_pkg::OP_PEEK:
                        begin
                            if (sp_reg == '0)
                            begin
                                status_next = sma_pkg::ST_UNDER;
                            end
                        end
                        default:
                        begin
                            status_next = sma_pkg::ST_OK;
                        end
                    endcase
                end
            end
            sma_pkg::S_LOAD:
            begin
                // top in top_reg, next arrives from the RAM this cycle
                add_sub   = (op_reg == sma_pkg::OP_SUB);
                res_next  = add_sum[sma_pkg::WORD_W-1:0];
                acc_next  = '0;
                step_next = '0;
                if (op_reg == sma_pkg::OP_MUL)
                begin
                    a_next = top_reg;
                    b_next = rd_data;
                end
                else
                begin
                    a_next = rd_data;
                    b_next = top_reg;
                end
                if ((op_reg == sma_pkg::OP_DIV) && (rd_data == '0))
                begin
                    status_next = sma_pkg::ST_DIVZ;
                end
            end
            sma_pkg::S_EXEC:
            begin
                step_next = step_reg + 1'b1;
                if (op_reg == sma_pkg::OP_MUL)
                begin
                    // shift-add, multiplier LSB first
                    add_x  = {1'b0, acc_reg};
                    add_y  = {1'b0, a_reg};
                    a_next = {a_reg[sma_pkg::WORD_W-2:0], 1'b0};
                    b_next = {1'b0, b_reg[sma_pkg::WORD_W-1:1]};
                    if (b_reg[0])
                    begin
                        acc_next = add_sum[sma_pkg::WORD_W-1:0];
                    end
                    res_next = acc_next;
                end
                else
                begin
                    // restoring divide: acc is the partial remainder
                    add_x   = {acc_reg, b_reg[sma_pkg::WORD_W-1]};
                    add_y   = {1'b0, a_reg};
                    add_sub = 1'b1;
                    if (add_sum[SUM_W-1])
                    begin
                        acc_next = add_sum[sma_pkg::WORD_W-1:0];
                    end
                    else
                    begin
                        acc_next = add_x[sma_pkg::WORD_W-1:0];
                    end
                    b_next   = {b_reg[sma_pkg::WORD_W-2:0], add_sum[SUM_W-1]};
                    res_next = b_next;
                end
            end
            sma_pkg::S_DONE:
            begin
                if (rsp_load)
                begin
                    if (commit)
                    begin
                        wr_en    = 1'b1;
                        top_next = res_reg;
                        if (is_binop)
                        begin
                            wr_addr = ADDR_W'(sp_reg - PTR_TWO);
                            sp_next = sp_reg - PTR_ONE;
                        end
                        else
                        begin
                            sp_next = sp_reg + PTR_ONE;
                        end
                    end
                    rsp_valid_next  = 1'b1;
                    rsp_top_next    = (sp_next == '0) ? '0 : top_next;
                    rsp_depth_next  = sma_pkg::DEPTH_W'(sp_next);
                    rsp_status_next = status_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sma_pkg::S_IDLE;
            sp_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        status_reg     <= status_next;
        res_reg        <= res_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        step_reg       <= step_next;
        top_reg        <= top_next;
        rsp_top_reg    <= rsp_top_next;
        rsp_depth_reg  <= rsp_depth_next;
        rsp_status_reg <= rsp_status_next;
    end

    sma_ram #(
        .WIDTH (sma_pkg::WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (res_reg),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(sp_reg - PTR_TWO)),
        .rd_data (rd_data)
    );

    assign req.ready       = (state_reg == sma_pkg::S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_value   = rsp_top_reg;
    assign rsp.stack_depth = rsp_depth_reg;
    assign rsp.status      = rsp_status_reg;

endmodule

/* src/sma_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module sma_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
